[src/ikw_pkg.sv]
// Shared constants, types and the sine table for the interpolation kernel weight block.
`timescale 1ns / 1ps

package ikw_pkg;

    // Fixed-point formats of the distance and the weight
    localparam int DIST_FRAC_BITS   = 12;
    localparam int WEIGHT_FRAC_BITS = 14;
    localparam int DIST_W           = 16;
    localparam int WEIGHT_W         = 16;

    // Quarter-wave sine table
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_HALF  = SINE_DEPTH / 2;
    localparam int SINE_LOG2  = $clog2(SINE_DEPTH);
    localparam int SINE_IDX_W = $clog2(SINE_DEPTH + 1);
    localparam int SINE_TAB_W = 21;
    localparam int SINE_W     = 22;
    localparam int PHASE_W    = $clog2(SINE_DEPTH) + 18;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    // pi^2 in Q13
    localparam int PI_SQ_Q13 = 80852;

    // Quotient bits of the normalizing divider
    localparam int QUOT_BITS = 18;

    // Kernel selection codes
    typedef enum logic [2:0] {
        KSEL_NEAREST  = 3'd0,
        KSEL_BILINEAR = 3'd1,
        KSEL_BICUBIC  = 3'd2,
        KSEL_LANCZOS2 = 3'd3,
        KSEL_LANCZOS3 = 3'd4
    } ksel_t;

    localparam ksel_t KSEL_RESET = KSEL_BICUBIC;

    // Sideband that rides along the divider
    typedef struct packed {
        logic               valid;
        logic               lz;
        logic               neg;
        logic signed [18:0] w16;
    } ikw_side_t;

    typedef logic [SINE_TAB_W-1:0] sine_tab_t [0:SINE_DEPTH];

    // Shift-and-subtract quotient, used only while building the table
    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned dvs);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            quo = quo << 1;
            if (rem >= dvs)
            begin
                rem = rem - dvs;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // Build the Q20 sine table from a Q30 Taylor series
    function automatic sine_tab_t build_sine();
        sine_tab_t         tab;
        longint unsigned   th;
        longint unsigned   t2;
        longint unsigned   term;
        longint            sum;
        longint            qv;
        for (int i = 0; i <= SINE_DEPTH; i++) begin
            th   = (PI_HALF_Q30 * longint'(i) + longint'(SINE_HALF)) >> SINE_LOG2;
            t2   = (th * th) >> 30;
            term = th;
            sum  = longint'(th);
            for (int n = 1; n < 40; n++) begin
                if (term != 0) begin
                    term = div_u64((term * t2) >> 30, longint'(4 * n * n + 2 * n));
                    if ((n & 1) == 1)
                    begin
                        sum = sum - longint'(term);
                    end
                    else
                    begin
                        sum = sum + longint'(term);
                    end
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            qv = (sum + 512) >>> 10;
            if (qv > (64'sd1 << 20))
            begin
                qv = 64'sd1 << 20;
            end
            tab[i] = SINE_TAB_W'(qv);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

endpackage

[src/ikw_sine.sv]
// Three-stage sine lookup with linear interpolation between table entries.
`timescale 1ns / 1ps

module ikw_sine (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic [ikw_pkg::PHASE_W-1:0]          phase,
    output logic signed [ikw_pkg::SINE_W-1:0]    sine
);
    import ikw_pkg::*;

    localparam int QW_BITS = $clog2(SINE_DEPTH) + 16;

    logic [1:0]            quad;
    logic [QW_BITS-1:0]    rem;
    logic [QW_BITS:0]      fold;
    logic [SINE_IDX_W-1:0] idx;
    logic [SINE_IDX_W-1:0] idx1;

    logic [SINE_TAB_W-1:0]     m0_reg;
    logic [SINE_TAB_W-1:0]     m1_reg;
    logic [15:0]               f_reg;
    logic                      neg1_reg;
    logic signed [SINE_W+17:0] dprod_reg;
    logic [SINE_TAB_W-1:0]     m2_reg;
    logic                      neg2_reg;
    logic signed [SINE_W-1:0]  sine_reg;

    logic signed [SINE_W-1:0]  diff;
    logic signed [SINE_W+17:0] rnd;
    logic signed [SINE_W-1:0]  mag;

    // Fold the phase into the first quarter wave
    assign quad = phase[QW_BITS+1:QW_BITS];
    assign rem  = phase[QW_BITS-1:0];
    assign fold = quad[0] ? ((QW_BITS+1)'(1) << QW_BITS) - (QW_BITS+1)'(rem)
                          : (QW_BITS+1)'(rem);
    assign idx  = fold[QW_BITS:16];
    assign idx1 = (idx == SINE_IDX_W'(SINE_DEPTH)) ? idx : idx + 1'b1;

    // Read both neighboring entries
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg   <= SINE_TAB[idx];
            m1_reg   <= SINE_TAB[idx1];
            f_reg    <= fold[15:0];
            neg1_reg <= quad[1];
        end
    end

    // Scale the step by the fraction
    assign diff = SINE_W'($signed({1'b0, m1_reg})) - SINE_W'($signed({1'b0, m0_reg}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dprod_reg <= (SINE_W+18)'(diff) * (SINE_W+18)'($signed({1'b0, f_reg}));
            m2_reg    <= m0_reg;
            neg2_reg  <= neg1_reg;
        end
    end

    // Round the step, add the base entry and apply the half-wave sign
    assign rnd = (dprod_reg + (SINE_W+18)'(32768)) >>> 16;
    assign mag = SINE_W'($signed({1'b0, m2_reg})) + SINE_W'(rnd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sine_reg <= '0;
        end
        else if (en)
        begin
            sine_reg <= neg2_reg ? -mag : mag;
        end
    end

    assign sine = sine_reg;

endmodule

[src/ikw_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
`timescale 1ns / 1ps

module ikw_div #(
    parameter int QW = ikw_pkg::QUOT_BITS,
    parameter int NW = 64,
    parameter int DW = 53
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [NW-1:0]         num,
    input  logic [DW-1:0]         den,
    input  ikw_pkg::ikw_side_t    side_in,
    output logic [QW-1:0]         quot,
    output ikw_pkg::ikw_side_t    side_out
);
    import ikw_pkg::*;

    logic [NW-1:0]  rem_reg  [QW];
    logic [DW-1:0]  den_reg  [QW];
    logic [QW-1:0]  quot_reg [QW];
    ikw_side_t      side_reg [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        localparam int B = QW - 1 - i;

        logic [NW-1:0]    rem_in;
        logic [DW-1:0]    den_in;
        logic [QW-1:0]    quot_in;
        ikw_side_t        side_i;
        logic [NW+QW-1:0] cmp;
        logic [NW+QW-1:0] rem_ext;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign rem_in  = num;
            assign den_in  = den;
            assign quot_in = '0;
            assign side_i  = side_in;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign quot_in = quot_reg[i-1];
            assign side_i  = side_reg[i-1];
        end

        // Try to subtract the shifted divisor
        assign cmp     = (NW+QW)'(den_in) << B;
        assign rem_ext = (NW+QW)'(rem_in);
        assign ge      = rem_ext >= cmp;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? NW'(rem_ext - cmp) : rem_in;
                den_reg[i]  <= den_in;
                quot_reg[i] <= quot_in | (QW'(ge) << B);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[i] <= '0;
            end
            else if (en)
            begin
                side_reg[i] <= side_i;
            end
        end
    end

    assign quot     = quot_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

[src/interpolation_kernel_weight.sv]
// Top level of the interpolation kernel weight pipeline.
//
// Channel   Direction  Fields (tdata, low bit first)
// s_*       in         distance[15:0] (signed Q4.12)
// m_*       out        weight[15:0] (signed Q2.14)
// cfg_*     in         kernel_select[2:0]
//
// One distance per cycle while the output is empty or taken: eight arithmetic
// stages (squares, cubes, two sine lookups, products), then 18 divider stages
// and the output register. All stages advance together under that condition,
// so a stall freezes every item in place. Reset clears valid bits and sets
// the kernel to bicubic.
`timescale 1ns / 1ps

module interpolation_kernel_weight #(
    parameter int QUOT_BITS = ikw_pkg::QUOT_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // distance[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // weight[15:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data
);
    import ikw_pkg::*;

    localparam int ONE16    = 65536;
    localparam int OUT_HALF = (WEIGHT_FRAC_BITS < 16) ? (1 << (15 - WEIGHT_FRAC_BITS)) : 0;

    logic en;
    ksel_t ksel_reg;

    // Stage registers
    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic [15:0]        d1_reg;
    ksel_t              k1_reg, k2_reg, k3_reg, k4_reg;
    logic [19:0]        a2_reg, a3_reg, a4_reg;
    logic signed [18:0] w2_reg, w3_reg, w4_reg;
    logic [30:0]        base2_reg, base3_reg;
    logic [30:0]        p2_3_reg;
    logic [39:0]        sq3_reg;
    logic [34:0]        sq4_reg;
    logic [52:0]        cube4_reg, den4_reg, den5_reg, den6_reg, den7_reg, den8_reg;
    ikw_side_t          side5_reg, side6_reg, side7_reg, side8_reg;
    logic               big5_reg, big6_reg, big7_reg;
    logic signed [43:0] pp7_reg;
    logic [63:0]        num8_reg;
    logic               m_tvalid_reg;
    logic [15:0]        m_tdata_reg;

    // Stage 1 combinational
    logic signed [19:0] xi1;
    logic [19:0]        a1;
    logic signed [18:0] w1;

    // Stage 2 combinational
    logic [31:0]        n3;
    logic [63:0]        recip;
    logic [30:0]        p2_2;

    // Stage 3/4 combinational
    logic [52:0]        cube3;
    logic [52:0]        den3;
    logic signed [55:0] ybic;
    logic signed [55:0] yshift;
    logic signed [18:0] wbic;
    logic               lz4, zero4, out4;
    ikw_side_t          side4;

    // Sine and product
    logic signed [SINE_W-1:0] s1, s2;
    logic signed [45:0]       prodk;
    logic [45:0]              magk;
    logic                     neg7;

    // Divider output and final rounding
    logic [QUOT_BITS-1:0] quot;
    ikw_side_t            side_q;
    logic signed [20:0]   w16f;
    logic signed [20:0]   wr;
    logic [15:0]          wsat;

    // Whole pipeline moves when the output register can take a result
    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Hold the kernel register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ksel_reg <= KSEL_RESET;
        end
        else if (cfg_valid)
        begin
            ksel_reg <= ksel_t'(cfg_data);
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Capture input transfer
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg <= s_tdata;
            k1_reg <= ksel_reg;
        end
    end

    // Rescale to 16 fraction bits and handle nearest and bilinear
    assign xi1 = 20'($signed(d1_reg)) <<< (16 - DIST_FRAC_BITS);
    assign a1  = xi1[19] ? 20'(-xi1) : 20'(xi1);

    always_comb
    begin
        case (k1_reg)
            KSEL_NEAREST:
                w1 = (xi1 >= -20'sd32768 && xi1 < 20'sd32768) ? 19'sd65536 : 19'sd0;
            KSEL_BILINEAR:
                w1 = (a1 <= 20'(ONE16)) ? 19'(20'(ONE16) - a1) : 19'sd0;
            default:
                w1 = 19'sd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg    <= a1;
            k2_reg    <= k1_reg;
            w2_reg    <= w1;
            base2_reg <= 31'(a1) << 11;
        end
    end

    // Second sine phase: divide by the lobe count
    assign n3    = 32'(base2_reg) + 32'd1;
    assign recip = 64'(n3) * 64'h0000_0000_AAAA_AAAB;
    assign p2_2  = (k2_reg == KSEL_LANCZOS3) ? recip[63:33] : (base2_reg >> 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a3_reg    <= a2_reg;
            k3_reg    <= k2_reg;
            w3_reg    <= w2_reg;
            sq3_reg   <= 40'(a2_reg) * 40'(a2_reg);
            base3_reg <= base2_reg;
            p2_3_reg  <= p2_2;
        end
    end

    // Cube and the Lanczos denominator
    assign cube3 = 53'(sq3_reg[34:0]) * 53'(a3_reg[17:0]);
    assign den3  = 53'(sq3_reg[35:0]) * 53'(PI_SQ_Q13);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a4_reg    <= a3_reg;
            k4_reg    <= k3_reg;
            w4_reg    <= w3_reg;
            sq4_reg   <= sq3_reg[34:0];
            cube4_reg <= cube3;
            den4_reg  <= den3;
        end
    end

    // Two sine units on the two phases
    ikw_sine u_sine1 (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .phase (base3_reg[PHASE_W-1:0]),
        .sine  (s1)
    );

    ikw_sine u_sine2 (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .phase (p2_3_reg[PHASE_W-1:0]),
        .sine  (s2)
    );

    // Bicubic polynomial, exact before the final rounding
    always_comb
    begin
        if (a4_reg <= 20'(ONE16))
        begin
            ybic = 56'sd3 * 56'($signed({1'b0, cube4_reg}))
                 - 56'sd5 * (56'($signed({1'b0, sq4_reg})) <<< 16)
                 + (56'sd2 <<< 48);
        end
        else
        begin
            ybic = -56'($signed({1'b0, cube4_reg}))
                 + 56'sd5 * (56'($signed({1'b0, sq4_reg})) <<< 16)
                 - 56'sd8 * (56'($signed({1'b0, a4_reg})) <<< 32)
                 + (56'sd4 <<< 48);
        end
    end

    assign yshift = (ybic + (56'sd1 <<< 32)) >>> 33;
    assign wbic   = (a4_reg <= 20'(2 * ONE16)) ? 19'(yshift) : 19'sd0;

    // Lanczos special cases
    assign lz4   = (k4_reg == KSEL_LANCZOS2) || (k4_reg == KSEL_LANCZOS3);
    assign zero4 = (a4_reg == 20'd0);
    assign out4  = (k4_reg == KSEL_LANCZOS3) ? (a4_reg >= 20'(3 * ONE16))
                                             : (a4_reg >= 20'(2 * ONE16));

    always_comb
    begin
        side4.valid = v4_reg;
        side4.lz    = lz4 && !zero4 && !out4;
        side4.neg   = 1'b0;
        case (k4_reg)
            KSEL_BICUBIC:
                side4.w16 = wbic;
            KSEL_LANCZOS2, KSEL_LANCZOS3:
                side4.w16 = zero4 ? 19'sd65536 : 19'sd0;
            default:
                side4.w16 = w4_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side5_reg <= '0;
            side6_reg <= '0;
            side7_reg <= '0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
            v7_reg    <= 1'b0;
        end
        else if (en)
        begin
            side5_reg <= side4;
            side6_reg <= side5_reg;
            side7_reg <= side6_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            v7_reg    <= v6_reg;
        end
    end

    // Carry denominator and lobe count alongside the sine units
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den5_reg <= den4_reg;
            den6_reg <= den5_reg;
            den7_reg <= den6_reg;
            big5_reg <= (k4_reg == KSEL_LANCZOS3);
            big6_reg <= big5_reg;
            big7_reg <= big6_reg;
            pp7_reg  <= 44'(s1) * 44'(s2);
        end
    end

    // Scale by the lobe count and form the rounded dividend
    assign prodk = big7_reg ? (46'(pp7_reg) + (46'(pp7_reg) <<< 1)) : (46'(pp7_reg) <<< 1);
    assign neg7  = prodk[45];
    assign magk  = neg7 ? 46'(-prodk) : 46'(prodk);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side8_reg <= '0;
            v8_reg    <= 1'b0;
        end
        else if (en)
        begin
            side8_reg <= {side7_reg.valid, side7_reg.lz, neg7, side7_reg.w16};
            v8_reg    <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num8_reg <= (64'(magk) << 21) + 64'(den7_reg >> 1);
            den8_reg <= den7_reg;
        end
    end

    ikw_div #(
        .QW (QUOT_BITS),
        .NW (64),
        .DW (53)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .num      (num8_reg),
        .den      (den8_reg),
        .side_in  (side8_reg),
        .quot     (quot),
        .side_out (side_q)
    );

    // Pick the weight, round to output precision and saturate
    always_comb
    begin
        if (side_q.lz)
        begin
            w16f = side_q.neg ? -21'($signed({1'b0, quot})) : 21'($signed({1'b0, quot}));
        end
        else
        begin
            w16f = 21'(side_q.w16);
        end
    end

    assign wr = (w16f + 21'(OUT_HALF)) >>> (16 - WEIGHT_FRAC_BITS);

    always_comb
    begin
        if (wr > 21'sd32767)
        begin
            wsat = 16'h7FFF;
        end
        else if (wr < -21'sd32768)
        begin
            wsat = 16'h8000;
        end
        else
        begin
            wsat = wr[15:0];
        end
    end

    // Hold the result until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= side_q.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= wsat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A waiting result stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("pending result dropped");

    // Input side stalls only behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // Interpolated sines of a valid item stay within one
    assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg |-> ((s1 <= 22'sd1048576) && (s1 >= -22'sd1048576)
        && (s2 <= 22'sd1048576) && (s2 >= -22'sd1048576)))
        else $error("sine out of range");

    // Stage valid bit agrees with the divider sideband entry
    assert property (@(posedge clk) disable iff (!rst_n)
        v8_reg == side8_reg.valid)
        else $error("valid bits out of step");

endmodule

[bench/tb_top.sv]
// Testbench for the interpolation kernel weight block: table-driven and random distances.
`timescale 1ns / 1ps

module tb_top;
    import ikw_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 830;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // distance[15:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // weight[15:0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_data;

    interpolation_kernel_weight dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Directed stimulus row
    typedef struct {
        ksel_t       kern;
        logic [15:0] dist_val;
        bit          known;
        logic [15:0] weight;
    } dir_row_t;

    logic [15:0]  weight_q [$];
    longint       sine_q20_tab [0:1024];
    ksel_t        cur_kernel;
    int           errors;
    int           quiet_cycles;
    bit           idle_on;
    bit           hold_req;

    // Generate the clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Round to nearest, ties up, floor semantics on negatives
    function automatic longint rshift_round(longint y, int k);
        if (k == 0)
        begin
            return y;
        end
        return (y + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    // Fill the Q20 quarter-wave table from a Q30 Taylor series
    function automatic void fill_sine();
        longint unsigned th;
        longint unsigned t2;
        longint unsigned term;
        longint          sum;
        longint          qv;
        longint unsigned n;
        for (int i = 0; i <= 1024; i++)
        begin
            th   = (64'd1686629713 * longint'(i) + 512) / 1024;
            t2   = (th * th) >> 30;
            term = th;
            sum  = longint'(th);
            n    = 1;
            while (term != 0 && n < 40)
            begin
                term = ((term * t2) >> 30) / ((2 * n) * (2 * n + 1));
                sum  = n[0] ? sum - longint'(term) : sum + longint'(term);
                n++;
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            qv = (sum + 512) >>> 10;
            if (qv > (64'sd1 << 20))
            begin
                qv = 64'sd1 << 20;
            end
            sine_q20_tab[i] = qv;
        end
    endfunction

    // Sine in Q20 of a phase in table steps with 16 fraction bits
    function automatic longint sine_at(longint unsigned ph);
        longint unsigned quarter;
        longint unsigned q;
        longint unsigned r;
        longint unsigned v;
        longint unsigned idx;
        longint unsigned f;
        longint          m;
        quarter = 64'd1024 << 16;
        ph      = ph % (4 * quarter);
        q       = ph / quarter;
        r       = ph % quarter;
        v       = q[0] ? quarter - r : r;
        idx     = v >> 16;
        f       = v & 64'hFFFF;
        if (idx > 1024)
        begin
            idx = 1024;
        end
        m = sine_q20_tab[idx];
        if (idx < 1024)
        begin
            m = m + rshift_round((sine_q20_tab[idx + 1] - m) * longint'(f), 16);
        end
        return (q >= 2) ? -m : m;
    endfunction

    // Windowed sinc weight with 16 fraction bits
    function automatic longint lanczos_w16(longint a, longint k);
        longint unsigned base;
        longint unsigned p2;
        longint unsigned mag;
        longint unsigned den;
        longint          prod;
        bit              neg;
        if (a == 0)
        begin
            return 65536;
        end
        if (a >= k * 65536)
        begin
            return 0;
        end
        base = longint'(a) * 2048;
        p2   = (base + k / 2) / k;
        prod = k * sine_at(base) * sine_at(p2);
        neg  = prod < 0;
        mag  = longint'(neg ? -prod : prod) << 21;
        den  = 64'd80852 * a * a;
        mag  = (mag + den / 2) / den;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    // Compute the weight for one distance under the given kernel
    function automatic logic [15:0] kernel_weight(ksel_t kern, logic [15:0] dist_val);
        longint xi;
        longint a;
        longint w16;
        longint w;
        longint one;
        one = 65536;
        xi  = longint'($signed(dist_val)) * 16;
        a   = (xi < 0) ? -xi : xi;
        w16 = 0;
        case (kern)
            KSEL_NEAREST:  w16 = (xi >= -(one / 2) && xi < one / 2) ? one : 0;
            KSEL_BILINEAR: w16 = (a <= one) ? one - a : 0;
            KSEL_BICUBIC:
            begin
                if (a <= one)
                begin
                    w16 = rshift_round(3 * a * a * a - 5 * a * a * one + 2 * one * one * one, 33);
                end
                else if (a <= 2 * one)
                begin
                    w16 = rshift_round(-a * a * a + 5 * a * a * one - 8 * a * one * one
                                       + 4 * one * one * one, 33);
                end
            end
            KSEL_LANCZOS2: w16 = lanczos_w16(a, 2);
            KSEL_LANCZOS3: w16 = lanczos_w16(a, 3);
            default:       w16 = 0;
        endcase
        w = rshift_round(w16, 2);
        if (w > 32767)
        begin
            w = 32767;
        end
        if (w < -32768)
        begin
            w = -32768;
        end
        return w[15:0];
    endfunction

    // Wait until all weights are out, then write the kernel register
    task automatic set_kernel(ksel_t kern);
        while (weight_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= kern;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid  <= 1'b0;
        cur_kernel = kern;
    endtask

    // Offer one distance, with random gaps, and log its weight on transfer
    task automatic send_dist(logic [15:0] dist_val, bit known, logic [15:0] weight);
        while (idle_on && $urandom_range(0, 99) < 28)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= dist_val;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        weight_q.push_back(known ? weight : kernel_weight(cur_kernel, dist_val));
    endtask

    // Random distance, mostly within a span around the support of the kernel
    function automatic logic [15:0] pick_dist(ksel_t kern);
        int span;
        case (kern)
            KSEL_NEAREST:  span = 4096;
            KSEL_BILINEAR: span = 8192;
            KSEL_BICUBIC:  span = 12288;
            KSEL_LANCZOS2: span = 12288;
            default:       span = 16384;
        endcase
        if ($urandom_range(0, 99) < 70)
        begin
            return 16'($urandom_range(0, 2 * span) - span);
        end
        return 16'($urandom);
    endfunction

    // Stimulus
    initial
    begin
        dir_row_t rows [$];
        ksel_t    kern;
        int       count;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        errors    = 0;
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        cur_kernel = KSEL_RESET;
        fill_sine();
        rows = '{
            '{KSEL_BICUBIC,  16'h0000, 1, 16'd16384},
            '{KSEL_BICUBIC,  16'h2000, 1, 16'd0},
            '{KSEL_BICUBIC,  16'h1000, 0, 16'd0},
            '{KSEL_BICUBIC,  16'h8000, 1, 16'd0},
            '{KSEL_BICUBIC,  16'h7FFF, 1, 16'd0},
            '{KSEL_BICUBIC,  16'h1800, 0, 16'd0},
            '{KSEL_NEAREST,  16'h0000, 1, 16'd16384},
            '{KSEL_NEAREST,  16'h0800, 1, 16'd0},
            '{KSEL_NEAREST,  16'hF800, 1, 16'd16384},
            '{KSEL_NEAREST,  16'h07FF, 1, 16'd16384},
            '{KSEL_NEAREST,  16'h8000, 1, 16'd0},
            '{KSEL_BILINEAR, 16'h0000, 1, 16'd16384},
            '{KSEL_BILINEAR, 16'h1000, 1, 16'd0},
            '{KSEL_BILINEAR, 16'hF000, 1, 16'd0},
            '{KSEL_BILINEAR, 16'h0800, 1, 16'd8192},
            '{KSEL_LANCZOS2, 16'h0000, 1, 16'd16384},
            '{KSEL_LANCZOS2, 16'h2000, 1, 16'd0},
            '{KSEL_LANCZOS2, 16'h1FFF, 0, 16'd0},
            '{KSEL_LANCZOS2, 16'h0001, 0, 16'd0},
            '{KSEL_LANCZOS3, 16'h0000, 1, 16'd16384},
            '{KSEL_LANCZOS3, 16'h3000, 1, 16'd0},
            '{KSEL_LANCZOS3, 16'hD001, 0, 16'd0},
            '{KSEL_LANCZOS3, 16'h7FFF, 1, 16'd0}
        };
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table, rewriting the kernel where it changes
        foreach (rows[i])
        begin
            if (rows[i].kern != cur_kernel)
            begin
                s_tvalid <= 1'b0;
                set_kernel(rows[i].kern);
            end
            send_dist(rows[i].dist_val, rows[i].known, rows[i].weight);
        end

        // Random phases over all kernels, extremes included
        count = 0;
        while (count < RANDOM_ITEMS)
        begin
            kern = ksel_t'($urandom_range(0, 4));
            if (count == 0)
            begin
                kern = KSEL_NEAREST;
            end
            s_tvalid <= 1'b0;
            set_kernel(kern);
            repeat ($urandom_range(60, 160))
            begin
                idle_on = !(count >= 400 && count < 550);
                if (count == 250)
                begin
                    hold_req = 1'b1;
                end
                send_dist(pick_dist(kern), 0, 16'd0);
                count++;
            end
        end
        s_tvalid <= 1'b0;
        set_kernel(KSEL_LANCZOS3);

        // Drain and finish
        while (weight_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (weight_q.size() != 0)
        begin
            errors++;
        end
        if (errors == 0)
        begin
            $display("interpolation_kernel_weight test passed");
        end
        else
        begin
            $display("interpolation_kernel_weight test failed");
        end
        $finish;
    end

    // Receiver: random back-pressure, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                m_tready <= !idle_on || ($urandom_range(0, 99) >= 28);
            end
        end
    end

    // Compare each weight transfer with the oldest prediction
    always @(posedge clk)
    begin
        logic [15:0] exp_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (weight_q.size() == 0)
            begin
                $error("weight: unexpected transfer, actual %0d", $signed(m_tdata));
                errors++;
            end
            else
            begin
                exp_w = weight_q.pop_front();
                if (m_tdata !== exp_w)
                begin
                    $error("weight: expected %0d, actual %0d", $signed(exp_w),
                           $signed(m_tdata));
                    errors++;
                end
            end
        end
    end

    // Watchdog: stop when nothing transfers for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("interpolation_kernel_weight test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
